>>> sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/vna_pkg.sv
// shared types, codes and helpers of the vertex normal accumulator
package vna_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int SUM_W  = 40;
    localparam int NRM_W  = 16;
    localparam int EDGE_W = 17;
    localparam int PROD_W = 34;
    localparam int FN_W   = 35;

    // command codes on the input channel
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TRI   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // work kinds after classification
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_LOAD    = 3'd0;
    localparam logic [KIND_W-1:0] K_TRI     = 3'd1;
    localparam logic [KIND_W-1:0] K_READ    = 3'd2;
    localparam logic [KIND_W-1:0] K_CLEAR   = 3'd3;
    localparam logic [KIND_W-1:0] K_DROP    = 3'd4;
    localparam logic [KIND_W-1:0] K_BADREAD = 3'd5;

    localparam logic [NRM_W-1:0] ONE_Q14 = 16'd16384;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        vertex;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_stat_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
    } norm_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
        logic                    degen;
    } norm_res_t;

    // saturating add of a face normal component into a 40-bit sum
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [FN_W-1:0]  d
    );
        logic signed [SUM_W:0] s;
        logic signed [SUM_W-1:0] r;
        s = (SUM_W+1)'(acc) + (SUM_W+1)'(d);
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/vna_front.sv
// front end: takes input transfers, classifies them and queues the work
module vna_front #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [87:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output vna_pkg::head_t       head,
    input  vna_pkg::back_stat_t  stat
);

`include "assert_macros.svh"

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    vna_pkg::cmd_t  q_mem_reg [QD];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    vna_pkg::cmd_t  in_cmd;
    logic           accept;
    logic           vtx_ok, tri_ok;

    assign s_tready = (count_reg != (PW+1)'(QD)) && !stat.clearing;
    assign accept   = s_tvalid && s_tready;

    assign vtx_ok = 32'(s_tdata[9:0]) < 32'(MAX_VERTICES);
    assign tri_ok = (32'(s_tdata[67:58]) < 32'(MAX_VERTICES))
                 && (32'(s_tdata[77:68]) < 32'(MAX_VERTICES))
                 && (32'(s_tdata[87:78]) < 32'(MAX_VERTICES));

    always_comb begin
        in_cmd.vertex   = s_tdata[9:0];
        in_cmd.pos_x    = s_tdata[25:10];
        in_cmd.pos_y    = s_tdata[41:26];
        in_cmd.pos_z    = s_tdata[57:42];
        in_cmd.corner_a = s_tdata[67:58];
        in_cmd.corner_b = s_tdata[77:68];
        in_cmd.corner_c = s_tdata[87:78];
        unique case (s_tuser)
            vna_pkg::CMD_LOAD:  in_cmd.kind = vtx_ok ? vna_pkg::K_LOAD : vna_pkg::K_DROP;
            vna_pkg::CMD_TRI:   in_cmd.kind = tri_ok ? vna_pkg::K_TRI : vna_pkg::K_DROP;
            vna_pkg::CMD_READ:  in_cmd.kind = vtx_ok ? vna_pkg::K_READ : vna_pkg::K_BADREAD;
            vna_pkg::CMD_CLEAR: in_cmd.kind = vna_pkg::K_CLEAR;
            default:            in_cmd.kind = vna_pkg::K_DROP;
        endcase
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (stat.pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (accept && !stat.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!accept && stat.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assign head.valid = count_reg != '0;
    assign head.cmd   = q_mem_reg[rd_ptr_reg];

    `ASSERT_IMPLIES(a_q_bound, aclk, aresetn, 1'b1, count_reg <= (PW+1)'(QD))
    `ASSERT_IMPLIES(a_pop_nonempty, aclk, aresetn, stat.pop, count_reg != '0)

endmodule

>>> sv/vna_norm.sv
// normalizer: scales a sum to q1.14 with a serial square root and divider
module vna_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  vna_pkg::norm_req_t  req,
    output vna_pkg::norm_res_t  res
);

`include "assert_macros.svh"

    localparam logic [3:0] NS_IDLE  = 4'd0;
    localparam logic [3:0] NS_MAX   = 4'd1;
    localparam logic [3:0] NS_SHIFT = 4'd2;
    localparam logic [3:0] NS_SQ    = 4'd3;
    localparam logic [3:0] NS_SQRT  = 4'd4;
    localparam logic [3:0] NS_DIVI  = 4'd5;
    localparam logic [3:0] NS_DIV   = 4'd6;

    logic [3:0]  state_reg, state_next;
    logic [39:0] m_reg [3];
    logic [39:0] m_next [3];
    logic [2:0]  sgn_reg, sgn_next;
    logic [39:0] mx_reg, mx_next;
    logic [49:0] acc_reg, acc_next;
    logic [61:0] rad_reg, rad_next;
    logic [30:0] root_reg, root_next;
    logic [33:0] srem_reg, srem_next;
    logic [31:0] drem_reg, drem_next;
    logic [15:0] num_reg, num_next;
    logic [15:0] q_reg, q_next;
    logic [1:0]  comp_reg, comp_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic signed [15:0] out_reg [3];
    logic signed [15:0] out_next [3];
    logic        degen_reg, degen_next;
    logic        done_reg, done_next;

    logic [39:0] mx_c;
    logic [47:0] sq;
    logic [49:0] sq_sum;
    logic [35:0] st, strial;
    logic [44:0] numer;
    logic [31:0] dt;
    logic [15:0] qc;

    always_comb begin
        mx_c = m_reg[0];
        if (m_reg[1] > mx_c) mx_c = m_reg[1];
        if (m_reg[2] > mx_c) mx_c = m_reg[2];
        sq     = m_reg[comp_reg][23:0] * m_reg[comp_reg][23:0];
        sq_sum = acc_reg + 50'(sq);
        st     = {srem_reg, rad_reg[61:60]};
        strial = {3'b000, root_reg, 2'b01};
        numer  = {1'b0, m_reg[comp_reg][23:0], 20'b0} + 45'(root_reg[30:1]);
        dt     = {drem_reg[30:0], num_reg[15]};
    end

    always_comb begin
        state_next = state_reg;
        m_next     = m_reg;
        sgn_next   = sgn_reg;
        mx_next    = mx_reg;
        acc_next   = acc_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        drem_next  = drem_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg;
        degen_next = degen_reg;
        done_next  = 1'b0;
        qc         = '0;
        unique case (state_reg)
            NS_IDLE: begin
                if (req.start) begin
                    sgn_next  = {req.sz[39], req.sy[39], req.sx[39]};
                    m_next[0] = req.sx[39] ? 40'(-req.sx) : 40'(req.sx);
                    m_next[1] = req.sy[39] ? 40'(-req.sy) : 40'(req.sy);
                    m_next[2] = req.sz[39] ? 40'(-req.sz) : 40'(req.sz);
                    state_next = NS_MAX;
                end
            end
            NS_MAX: begin
                mx_next = mx_c;
                if (mx_c == '0) begin
                    // all-zero sum reads as the zero vector
                    out_next[0] = '0;
                    out_next[1] = '0;
                    out_next[2] = '0;
                    degen_next  = 1'b1;
                    done_next   = 1'b1;
                    state_next  = NS_IDLE;
                end else begin
                    state_next = NS_SHIFT;
                end
            end
            NS_SHIFT: begin
                if (mx_reg[39:24] != '0) begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] >> 1;
                end else if (!mx_reg[23]) begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 3; i++) m_next[i] = m_reg[i] << 1;
                end else begin
                    acc_next   = '0;
                    comp_next  = '0;
                    state_next = NS_SQ;
                end
            end
            NS_SQ: begin
                acc_next  = sq_sum;
                comp_next = comp_reg + 1'b1;
                if (comp_reg == 2'd2) begin
                    rad_next   = {sq_sum, 12'b0};
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = '0;
                    state_next = NS_SQRT;
                end
            end
            NS_SQRT: begin
                // one root bit per cycle
                if (st >= strial) begin
                    srem_next = 34'(st - strial);
                    root_next = {root_reg[29:0], 1'b1};
                end else begin
                    srem_next = 34'(st);
                    root_next = {root_reg[29:0], 1'b0};
                end
                rad_next = {rad_reg[59:0], 2'b00};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd30) begin
                    comp_next  = '0;
                    state_next = NS_DIVI;
                end
            end
            NS_DIVI: begin
                drem_next  = 32'(numer[44:16]);
                num_next   = numer[15:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = NS_DIV;
            end
            NS_DIV: begin
                // one quotient bit per cycle, rounded by the half-length bias
                if (dt >= {1'b0, root_reg}) begin
                    drem_next = dt - {1'b0, root_reg};
                    q_next    = {q_reg[14:0], 1'b1};
                end else begin
                    drem_next = dt;
                    q_next    = {q_reg[14:0], 1'b0};
                end
                num_next = {num_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd15) begin
                    qc = (q_next > vna_pkg::ONE_Q14) ? vna_pkg::ONE_Q14 : q_next;
                    out_next[comp_reg] = sgn_reg[comp_reg] ? -$signed(qc) : $signed(qc);
                    if (comp_reg == 2'd2) begin
                        degen_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = NS_IDLE;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = NS_DIVI;
                    end
                end
            end
            default: state_next = NS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        sgn_reg   <= sgn_next;
        mx_reg    <= mx_next;
        acc_reg   <= acc_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        drem_reg  <= drem_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        comp_reg  <= comp_next;
        cnt_reg   <= cnt_next;
        out_reg   <= out_next;
        degen_reg <= degen_next;
    end

    assign res.done  = done_reg;
    assign res.x     = out_reg[0];
    assign res.y     = out_reg[1];
    assign res.z     = out_reg[2];
    assign res.degen = degen_reg;

    `ASSERT_IMPLIES(a_unit_range, aclk, aresetn, done_reg,
        (out_reg[0] <= 16'sd16384) && (out_reg[0] >= -16'sd16384))

endmodule

>>> sv/vna_back.sv
// back end: position and sum stores, face normal, accumulation and read out
module vna_back #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vna_pkg::head_t       head,
    output vna_pkg::back_stat_t  stat,
    output vna_pkg::norm_req_t   nrm_req,
    input  vna_pkg::norm_res_t   nrm_res,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic                 m_tuser
);

`include "assert_macros.svh"

    localparam int DEPTH = (MAX_VERTICES > 1024) ? 1024 : MAX_VERTICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TA   = 4'd1;
    localparam logic [3:0] S_TB   = 4'd2;
    localparam logic [3:0] S_TC   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_SRD  = 4'd5;
    localparam logic [3:0] S_SWR  = 4'd6;
    localparam logic [3:0] S_RDW  = 4'd7;
    localparam logic [3:0] S_NORM = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_CLR  = 4'd10;

    logic [47:0]  pos_mem [DEPTH];
    logic [119:0] sum_mem [DEPTH];
    logic [47:0]  pos_rd_reg;
    logic [119:0] sum_rd_reg;

    logic          pos_we, sum_we;
    logic [AW-1:0] pos_ra, sum_ra, sum_wa;
    logic [119:0]  sum_wd;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [2:0]    mstep_reg, mstep_next;
    logic [1:0]    corner_reg, corner_next;
    logic [AW-1:0] ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic [9:0]    vtx_reg, vtx_next;
    logic          bad_reg, bad_next;
    logic signed [15:0] pax_reg, pax_next, pay_reg, pay_next, paz_reg, paz_next;
    logic signed [16:0] e1x_reg, e1x_next, e1y_reg, e1y_next, e1z_reg, e1z_next;
    logic signed [16:0] e2x_reg, e2x_next, e2y_reg, e2y_next, e2z_reg, e2z_next;
    logic signed [33:0] prod_reg, prod_next;
    logic signed [34:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;

    logic          out_valid_reg, out_valid_next;
    logic [9:0]    out_vtx_reg, out_vtx_next;
    logic signed [15:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic signed [15:0] out_z_reg, out_z_next;
    logic          out_degen_reg, out_degen_next;

    logic          pop;
    logic [AW-1:0] corner_addr;
    logic signed [16:0] mul_a, mul_b;
    logic signed [15:0] rd_x, rd_y, rd_z;

    assign pop  = (state_reg == S_IDLE) && head.valid;
    assign rd_x = $signed(pos_rd_reg[15:0]);
    assign rd_y = $signed(pos_rd_reg[31:16]);
    assign rd_z = $signed(pos_rd_reg[47:32]);

    always_comb begin
        case (corner_reg)
            2'd0:    corner_addr = ca_reg;
            2'd1:    corner_addr = cb_reg;
            default: corner_addr = cc_reg;
        endcase
    end

    always_comb begin
        case (mstep_reg)
            3'd0:    begin mul_a = e1y_reg; mul_b = e2z_reg; end
            3'd1:    begin mul_a = e1z_reg; mul_b = e2y_reg; end
            3'd2:    begin mul_a = e1z_reg; mul_b = e2x_reg; end
            3'd3:    begin mul_a = e1x_reg; mul_b = e2z_reg; end
            3'd4:    begin mul_a = e1x_reg; mul_b = e2y_reg; end
            3'd5:    begin mul_a = e1y_reg; mul_b = e2x_reg; end
            default: begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    always_comb begin
        pos_we = pop && (head.cmd.kind == vna_pkg::K_LOAD);
        case (state_reg)
            S_TA:    pos_ra = cb_reg;
            S_TB:    pos_ra = cc_reg;
            S_IDLE:  pos_ra = head.cmd.corner_a[AW-1:0];
            default: pos_ra = ca_reg;
        endcase
        sum_ra = (state_reg == S_IDLE) ? head.cmd.vertex[AW-1:0] : corner_addr;
        sum_we = (state_reg == S_SWR) || (state_reg == S_CLR);
        sum_wa = (state_reg == S_CLR) ? cnt_reg : corner_addr;
        if (state_reg == S_CLR) begin
            sum_wd = '0;
        end else begin
            sum_wd = {vna_pkg::sat_add($signed(sum_rd_reg[119:80]), nz_reg),
                      vna_pkg::sat_add($signed(sum_rd_reg[79:40]), ny_reg),
                      vna_pkg::sat_add($signed(sum_rd_reg[39:0]), nx_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[head.cmd.vertex[AW-1:0]] <= {head.cmd.pos_z, head.cmd.pos_y,
                                                 head.cmd.pos_x};
        end
        pos_rd_reg <= pos_mem[pos_ra];
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_wa] <= sum_wd;
        end
        sum_rd_reg <= sum_mem[sum_ra];
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mstep_next     = mstep_reg;
        corner_next    = corner_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        cc_next        = cc_reg;
        vtx_next       = vtx_reg;
        bad_next       = bad_reg;
        pax_next       = pax_reg;
        pay_next       = pay_reg;
        paz_next       = paz_reg;
        e1x_next       = e1x_reg;
        e1y_next       = e1y_reg;
        e1z_next       = e1z_reg;
        e2x_next       = e2x_reg;
        e2y_next       = e2y_reg;
        e2z_next       = e2z_reg;
        prod_next      = prod_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nz_next        = nz_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_vtx_next   = out_vtx_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_degen_next = out_degen_reg;
        nrm_req.start  = 1'b0;
        nrm_req.sx     = $signed(sum_rd_reg[39:0]);
        nrm_req.sy     = $signed(sum_rd_reg[79:40]);
        nrm_req.sz     = $signed(sum_rd_reg[119:80]);
        unique case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    vtx_next = head.cmd.vertex;
                    ca_next  = head.cmd.corner_a[AW-1:0];
                    cb_next  = head.cmd.corner_b[AW-1:0];
                    cc_next  = head.cmd.corner_c[AW-1:0];
                    bad_next = 1'b0;
                    case (head.cmd.kind)
                        vna_pkg::K_TRI:     state_next = S_TA;
                        vna_pkg::K_READ:    state_next = S_RDW;
                        vna_pkg::K_BADREAD: begin
                            bad_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        vna_pkg::K_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_TA: begin
                pax_next   = rd_x;
                pay_next   = rd_y;
                paz_next   = rd_z;
                state_next = S_TB;
            end
            S_TB: begin
                e1x_next   = 17'(rd_x) - 17'(pax_reg);
                e1y_next   = 17'(rd_y) - 17'(pay_reg);
                e1z_next   = 17'(rd_z) - 17'(paz_reg);
                state_next = S_TC;
            end
            S_TC: begin
                e2x_next   = 17'(rd_x) - 17'(pax_reg);
                e2y_next   = 17'(rd_y) - 17'(pay_reg);
                e2z_next   = 17'(rd_z) - 17'(paz_reg);
                mstep_next = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                // one product per cycle, registered and then folded into its component
                prod_next  = mul_a * mul_b;
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    3'd1:    nx_next = 35'(prod_reg);
                    3'd2:    nx_next = nx_reg - 35'(prod_reg);
                    3'd3:    ny_next = 35'(prod_reg);
                    3'd4:    ny_next = ny_reg - 35'(prod_reg);
                    3'd5:    nz_next = 35'(prod_reg);
                    3'd6:    nz_next = nz_reg - 35'(prod_reg);
                    default: nx_next = nx_reg;
                endcase
                if (mstep_reg == 3'd6) begin
                    corner_next = '0;
                    state_next  = S_SRD;
                end
            end
            S_SRD: state_next = S_SWR;
            S_SWR: begin
                corner_next = corner_reg + 1'b1;
                state_next  = (corner_reg == 2'd2) ? S_IDLE : S_SRD;
            end
            S_RDW: begin
                nrm_req.start = 1'b1;
                state_next    = S_NORM;
            end
            S_NORM: begin
                if (nrm_res.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_vtx_next   = vtx_reg;
                    out_x_next     = bad_reg ? '0 : nrm_res.x;
                    out_y_next     = bad_reg ? '0 : nrm_res.y;
                    out_z_next     = bad_reg ? '0 : nrm_res.z;
                    out_degen_next = bad_reg ? 1'b1 : nrm_res.degen;
                    state_next     = S_IDLE;
                end
            end
            S_CLR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(DEPTH-1)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mstep_reg     <= mstep_next;
        corner_reg    <= corner_next;
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        cc_reg        <= cc_next;
        vtx_reg       <= vtx_next;
        bad_reg       <= bad_next;
        pax_reg       <= pax_next;
        pay_reg       <= pay_next;
        paz_reg       <= paz_next;
        e1x_reg       <= e1x_next;
        e1y_reg       <= e1y_next;
        e1z_reg       <= e1z_next;
        e2x_reg       <= e2x_next;
        e2y_reg       <= e2y_next;
        e2z_reg       <= e2z_next;
        prod_reg      <= prod_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        nz_reg        <= nz_next;
        out_vtx_reg   <= out_vtx_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_z_reg     <= out_z_next;
        out_degen_reg <= out_degen_next;
    end

    assign stat.pop      = pop;
    assign stat.clearing = state_reg == S_CLR;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_z_reg, out_y_reg, out_x_reg, out_vtx_reg};
    assign m_tuser  = out_degen_reg;

    `ASSERT_NEXT(a_clear_enter, aclk, aresetn,
        pop && (head.cmd.kind == vna_pkg::K_CLEAR), state_reg == S_CLR)
    `ASSERT_IMPLIES(a_done_waited, aclk, aresetn, nrm_res.done, state_reg == S_NORM)
    `ASSERT_IMPLIES(a_degen_zero, aclk, aresetn, out_valid_reg && out_degen_reg,
        (out_x_reg == '0) && (out_y_reg == '0) && (out_z_reg == '0))

endmodule

>>> sv/vertex_normal_accumulator.sv
// area-weighted vertex normal accumulator, top level
// load: one write in the back end; clear: a sweep over min(MAX_VERTICES,1024) sums
// add triangle: 3 position reads, 6 products on one multiplier, then a read-modify-write
//   per corner on the sum store, which has one read port and one write port
// read normal: a scaling shift of up to 23 single-bit steps, the 31-step square root
//   and three divisions, one per component; an all-zero sum stops at the maximum search
// reset is synchronous; a sweep over min(MAX_VERTICES,1024) entries then zeroes the sums
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex[9:0] pos_x[25:10] pos_y[41:26] pos_z[57:42]
    // corner_a[67:58] corner_b[77:68] corner_c[87:78]
    input  logic [87:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // vertex_out[9:0] normal_x[25:10] normal_y[41:26] normal_z[57:42]
    output logic [63:0] m_tdata,
    // degenerate[0]
    output logic        m_tuser
);

    // queue head from the front end, pop and clearing status back to it
    vna_pkg::head_t      head;
    vna_pkg::back_stat_t stat;

    // normalizer request and result
    vna_pkg::norm_req_t  nrm_req;
    vna_pkg::norm_res_t  nrm_res;

    // front: classifies each transfer and queues it, four entries deep
    vna_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .stat     (stat)
    );

    // back: stores, cross product, saturating accumulation and output register
    vna_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .nrm_req  (nrm_req),
        .nrm_res  (nrm_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // serial normalizer used by read commands
    vna_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nrm_req),
        .res     (nrm_res)
    );

endmodule
